@@ sv/l2rls_pkg.sv @@
// ----------------------------------------------------------------------------
// l2rls_pkg: shared types and constants
// Item and result records, register map and back-end states of the
// regularised label score block.
// ----------------------------------------------------------------------------
`default_nettype none

package l2rls_pkg;

	localparam int ADDR_W = 3;
	localparam logic [0:0] REG_L2_WEIGHT = 1'b0;
	localparam logic [31:0] L2_WEIGHT_RESET = 32'h0001_0000;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int DIV_STEPS = 32;
	localparam int DCNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic signed [32:0] g;
		logic signed [34:0] d;
		logic               last;
	} item_t;

	typedef struct packed {
		logic signed [31:0] label_score;
		logic signed [47:0] label_quality;
		logic signed [47:0] overall_quality;
		logic               is_last;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_DIV,
		ST_SCORE,
		ST_MUL_P1,
		ST_MUL_S2,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_SUM,
		ST_QUAL,
		ST_EMIT
	} back_state_t;

endpackage

`default_nettype wire

@@ sv/l2rls_front.sv @@
// ----------------------------------------------------------------------------
// l2rls_front: input stage and item queue
// Forms the gradient, Hessian and denominator of each label and holds the
// items in a short queue until the back end takes them.
// ----------------------------------------------------------------------------
`default_nettype none

module l2rls_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire logic signed [31:0]  covered_grad,
	input  wire logic signed [31:0]  covered_hess,
	input  wire logic signed [31:0]  total_grad,
	input  wire logic signed [31:0]  total_hess,
	input  wire logic                use_complement,
	input  wire logic                last_label,
	input  wire logic [31:0]         l2_weight,
	input  wire logic                take,
	output logic                     item_valid,
	output l2rls_pkg::item_t         item
);
	import l2rls_pkg::*;

	item_t             ent_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] cnt_q;
	item_t             new_item;
	logic signed [32:0] g;
	logic signed [32:0] h;
	logic              push_acc;
	logic              take_acc;

	always_comb begin
		if (use_complement) begin
			g = 33'(total_grad) - 33'(covered_grad);
			h = 33'(total_hess) - 33'(covered_hess);
		end else begin
			g = 33'(covered_grad);
			h = 33'(covered_hess);
		end
		new_item.g    = g;
		new_item.d    = 35'(h) + 35'($signed({3'b000, l2_weight}));
		new_item.last = last_label;
	end

	assign full       = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign item_valid = (cnt_q != '0);
	assign item       = ent_q[rptr_q];
	assign push_acc   = push && !full;
	assign take_acc   = take && item_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push_acc) begin
				wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (take_acc) begin
				rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push_acc && !take_acc) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (take_acc && !push_acc) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_acc) begin
			ent_q[wptr_q] <= new_item;
		end
	end

endmodule

`default_nettype wire

@@ sv/l2rls_back.sv @@
// ----------------------------------------------------------------------------
// l2rls_back: score and quality sequencer
// Divides for the leaf score one bit per cycle, forms the quality terms with
// a sequence of narrow products and keeps the running quality total.
// ----------------------------------------------------------------------------
`default_nettype none

module l2rls_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                item_valid,
	input  wire l2rls_pkg::item_t    item,
	output logic                     take,
	input  wire logic                out_free,
	output logic                     res_valid,
	output l2rls_pkg::result_t       res
);
	import l2rls_pkg::*;

	back_state_t        state_q;
	back_state_t        state_nx;

	logic signed [32:0] g_q;
	logic signed [34:0] d_q;
	logic               last_q;
	logic [32:0]        mag_g_q;
	logic [34:0]        mag_d_q;
	logic               neg_q;
	logic               zero_q;
	logic               ovf_q;
	logic [34:0]        rem_q;
	logic [31:0]        dvd_q;
	logic [31:0]        quo_q;
	logic [DCNT_W-1:0]  cnt_q;
	logic signed [31:0] score_q;
	logic [31:0]        mag_s_q;
	logic signed [64:0] p1_q;
	logic [63:0]        s2_q;
	logic [66:0]        plo_q;
	logic [66:0]        phi_q;
	logic signed [48:0] term1_q;
	logic signed [61:0] term2_q;
	logic signed [47:0] qual_q;
	logic signed [47:0] acc_q;

	logic [32:0]        gu;
	logic [34:0]        du;
	logic [35:0]        rem_sh;
	logic               rem_ge;
	logic signed [31:0] score_nx;
	logic [31:0]        mag_s_nx;
	logic signed [64:0] p1;
	logic [98:0]        full_prod;
	logic [60:0]        t2;
	logic signed [63:0] qsum;
	logic signed [47:0] qsat;
	logic signed [48:0] osum;
	logic signed [47:0] osat;

	function automatic logic item_d_zero();
		return (d_q == '0);
	endfunction

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:   if (item_valid) state_nx = ST_SETUP;
			ST_SETUP: begin
				if ((item_d_zero()) || (mag_g_q[32:16] >= mag_d_q)) begin
					state_nx = ST_SCORE;
				end else begin
					state_nx = ST_DIV;
				end
			end
			ST_DIV:    if (cnt_q == DCNT_W'(DIV_STEPS - 1)) state_nx = ST_SCORE;
			ST_SCORE:  state_nx = ST_MUL_P1;
			ST_MUL_P1: state_nx = ST_MUL_S2;
			ST_MUL_S2: state_nx = ST_MUL_LO;
			ST_MUL_LO: state_nx = ST_MUL_HI;
			ST_MUL_HI: state_nx = ST_SUM;
			ST_SUM:    state_nx = ST_QUAL;
			ST_QUAL:   state_nx = ST_EMIT;
			ST_EMIT:   if (out_free) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		take      = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: take      = item_valid;
			ST_EMIT: res_valid = out_free;
			default: begin
				take      = 1'b0;
				res_valid = 1'b0;
			end
		endcase
	end

	always_comb begin
		gu = item.g;
		du = item.d;
		rem_sh = {rem_q, dvd_q[31]};
		rem_ge = (rem_sh >= {1'b0, mag_d_q});

		if (zero_q) begin
			score_nx = '0;
			mag_s_nx = '0;
		end else if (neg_q) begin
			if (ovf_q || quo_q[31]) begin
				score_nx = 32'sh8000_0000;
				mag_s_nx = 32'h8000_0000;
			end else begin
				score_nx = $signed(~quo_q + 32'd1);
				mag_s_nx = quo_q;
			end
		end else begin
			if (ovf_q || (quo_q >= 32'h7FFF_FFFF)) begin
				score_nx = 32'sh7FFF_FFFF;
				mag_s_nx = 32'h7FFF_FFFF;
			end else begin
				score_nx = $signed(quo_q);
				mag_s_nx = quo_q;
			end
		end

		p1 = g_q * score_q;

		full_prod = {phi_q, 32'd0} + 99'(plo_q);
		if (full_prod[98:93] != '0) begin
			t2 = 61'h1 << 60;
		end else begin
			t2 = {1'b0, full_prod[92:33]};
		end

		qsum = 64'(term1_q) + 64'(term2_q);
		if (qsum[63:47] != {17{qsum[63]}}) begin
			qsat = qsum[63] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
		end else begin
			qsat = qsum[47:0];
		end

		osum = 49'(acc_q) + 49'(qual_q);
		if (osum[48] != osum[47]) begin
			osat = osum[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
		end else begin
			osat = osum[47:0];
		end

		res.label_score     = score_q;
		res.label_quality   = qual_q;
		res.overall_quality = osat;
		res.is_last         = last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			acc_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (res_valid) begin
				acc_q <= last_q ? '0 : osat;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				g_q     <= item.g;
				d_q     <= item.d;
				last_q  <= item.last;
				mag_g_q <= gu[32] ? (~gu + 33'd1) : gu;
				mag_d_q <= du[34] ? (~du + 35'd1) : du;
			end
			ST_SETUP: begin
				zero_q <= item_d_zero();
				ovf_q  <= ({18'd0, mag_g_q[32:16]} >= mag_d_q);
				neg_q  <= (g_q != '0) && (g_q[32] == d_q[34]);
				rem_q  <= {18'd0, mag_g_q[32:16]};
				dvd_q  <= {mag_g_q[15:0], 16'd0};
				quo_q  <= '0;
				cnt_q  <= '0;
			end
			ST_DIV: begin
				rem_q <= rem_ge ? 35'(rem_sh - {1'b0, mag_d_q}) : rem_sh[34:0];
				quo_q <= {quo_q[30:0], rem_ge};
				dvd_q <= {dvd_q[30:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
			end
			ST_SCORE: begin
				score_q <= score_nx;
				mag_s_q <= mag_s_nx;
			end
			ST_MUL_P1: p1_q  <= p1;
			ST_MUL_S2: s2_q  <= mag_s_q * mag_s_q;
			ST_MUL_LO: plo_q <= s2_q[31:0] * mag_d_q;
			ST_MUL_HI: phi_q <= s2_q[63:32] * mag_d_q;
			ST_SUM: begin
				term1_q <= p1_q[64:16];
				term2_q <= d_q[34] ? -$signed(62'(t2)) : $signed(62'(t2));
			end
			ST_QUAL: qual_q <= qsat;
			ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ sv/l2_regularized_label_score_top.sv @@
// ----------------------------------------------------------------------------
// l2_regularized_label_score_top: regularised Newton leaf score per label
// Computes the leaf score and quality of each label and sums the qualities
// over one rule evaluation.
// ----------------------------------------------------------------------------
// Labels enter through a queue-style port: a transfer happens when push is
// high and full is low. Two labels may wait in the input queue while the
// back end works. Results leave through a one-entry output register: the
// oldest result is shown while empty is low and is transferred when pop is
// high. Each label yields exactly one result.
// The back end works on one label at a time: it loads the item, sets it up,
// runs the bit-serial divide, saturates the score, forms the products, the
// sums and the quality, and delivers the result. With a zero denominator or a
// saturated quotient the divide is skipped. The back end takes the next label
// only after delivering the last one; meanwhile the input queue accepts new
// labels. When pop is held low the finished result waits, the back end holds
// in its delivery step and the input queue fills, raising full.
// Reset empties both queues, clears the quality total and sets l2_weight to
// 1.0. The user must see that the register is written through the APB port
// while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module l2_regularized_label_score_top (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [l2rls_pkg::ADDR_W-1:0]         paddr,
	input  wire logic [31:0]                          pwdata,
	output logic [31:0]                               prdata,
	output logic                                      pready,
	input  wire logic                                 push,
	output logic                                      full,
	input  wire logic signed [31:0]                   covered_grad,
	input  wire logic signed [31:0]                   covered_hess,
	input  wire logic signed [31:0]                   total_grad,
	input  wire logic signed [31:0]                   total_hess,
	input  wire logic                                 use_complement,
	input  wire logic                                 last_label,
	output logic                                      empty,
	input  wire logic                                 pop,
	output logic signed [31:0]                        label_score,
	output logic signed [47:0]                        label_quality,
	output logic signed [47:0]                        overall_quality,
	output logic                                      is_last
);
	import l2rls_pkg::*;

	logic [31:0] l2_weight_q;
	item_t       item;
	logic        item_valid;
	logic        take;
	logic        res_valid;
	result_t     res;
	result_t     out_q;
	logic        out_valid_q;
	logic        out_free;
	logic        reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[ADDR_W-1:2] == REG_L2_WEIGHT);
	assign prdata  = reg_sel ? l2_weight_q : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l2_weight_q <= L2_WEIGHT_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			l2_weight_q <= pwdata;
		end
	end

	l2rls_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.covered_grad   (covered_grad),
		.covered_hess   (covered_hess),
		.total_grad     (total_grad),
		.total_hess     (total_hess),
		.use_complement (use_complement),
		.last_label     (last_label),
		.l2_weight      (l2_weight_q),
		.take           (take),
		.item_valid     (item_valid),
		.item           (item)
	);

	l2rls_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.take       (take),
		.out_free   (out_free),
		.res_valid  (res_valid),
		.res        (res)
	);

	assign out_free = !out_valid_q || pop;
	assign empty    = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign label_score     = out_q.label_score;
	assign label_quality   = out_q.label_quality;
	assign overall_quality = out_q.overall_quality;
	assign is_last         = out_q.is_last;

endmodule

`default_nettype wire
